FILE: rtl/core/jdc_pkg.sv
// Shared constants and lookup function for the Julian date to calendar converter.
package jdc_pkg;

    localparam int unsigned FRAC_BITS_DEF  = 16;
    localparam int unsigned DAY_BITS_DEF   = 23;

    localparam int unsigned MIN_PER_DAY    = 1440;
    localparam int unsigned MIN_PER_HOUR   = 60;
    localparam int unsigned HOUR_SHIFT     = 20;
    localparam int unsigned HOUR_MUL       = ((1 << HOUR_SHIFT) + MIN_PER_HOUR - 1) / MIN_PER_HOUR;

    localparam int unsigned GREG_START     = 2299161;
    localparam int unsigned ALPHA_OFS      = 7468865;
    localparam int unsigned ALPHA_DIV      = 146097;
    localparam int unsigned B_OFS          = 1524;
    localparam int unsigned C_OFS          = 2442;
    localparam int unsigned C_DIV          = 7305;
    localparam int unsigned D_MUL          = 1461;
    localparam int unsigned YEAR_OFS_LATE  = 4716;
    localparam int unsigned YEAR_OFS_EARLY = 4715;

    localparam int unsigned BD_W           = 9;
    localparam int unsigned BD_MIN         = 123;
    localparam int unsigned BD_MAX         = 488;

    localparam logic [3:0] MONTH_FEB       = 4'd2;
    localparam logic [3:0] E_MONTH_WRAP    = 4'd14;
    localparam logic [3:0] E_OFS_EARLY     = 4'd1;
    localparam logic [3:0] E_OFS_LATE      = 4'd13;

    // floor(30.6001 * e): days before month slot e
    function automatic logic [BD_W-1:0] e_days(input logic [3:0] e);
        logic [BD_W-1:0] days;
        case (e)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd30;
            4'd2:    days = 9'd61;
            4'd3:    days = 9'd91;
            4'd4:    days = 9'd122;
            4'd5:    days = 9'd153;
            4'd6:    days = 9'd183;
            4'd7:    days = 9'd214;
            4'd8:    days = 9'd244;
            4'd9:    days = 9'd275;
            4'd10:   days = 9'd306;
            4'd11:   days = 9'd336;
            4'd12:   days = 9'd367;
            4'd13:   days = 9'd397;
            4'd14:   days = 9'd428;
            default: days = 9'd459;
        endcase
        return days;
    endfunction

endpackage

FILE: rtl/core/julian_date_to_calendar.sv
// Pipelined conversion of a fixed-point Julian date to calendar date and time of day.

// julian_date_to_calendar takes one Julian date per cycle while date_stall is
// low (unsigned, DAY_BITS integer and FRAC_BITS fraction bits) and returns
// year (astronomical numbering, two's complement), month, day_of_month, hour
// and minute. The date is rounded down to a whole minute after adding half a
// day; day numbers below 2299161 use the Julian calendar, later ones the
// Gregorian. The result passes through ten register stages: minute scaling,
// day split, two stages for the reciprocal-multiply division by 146097, the
// Gregorian correction, two stages for the reciprocal-multiply division by
// 7305, the 1461/4 day count, the month search and the final assembly. Each
// stage has its own valid bit, and a stalled stage only holds the stages
// behind it that are full, so bubbles close up and the input keeps taking
// transfers while a finished result waits on cal_stall, until every stage is
// full.
module julian_date_to_calendar #(
    parameter int unsigned FRAC_BITS = jdc_pkg::FRAC_BITS_DEF,
    parameter int unsigned DAY_BITS  = jdc_pkg::DAY_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          date_valid,
    output logic                          date_stall,
    input  logic [DAY_BITS+FRAC_BITS-1:0] julian_date,
    output logic                          cal_valid,
    input  logic                          cal_stall,
    output logic signed [15:0]            year,
    output logic [3:0]                    month,
    output logic [4:0]                    day_of_month,
    output logic [4:0]                    hour,
    output logic [5:0]                    minute
);

    localparam int unsigned NST  = 10;
    localparam int unsigned ZW   = DAY_BITS + 1;     // day number incl. rounding carry
    localparam int unsigned XAW  = ZW + 2;           // 4*Z - offset
    localparam int unsigned MAW  = XAW - 17;         // reciprocal of 146097, also alpha width
    localparam int unsigned BW   = ZW + 1;           // A and B
    localparam int unsigned X2W  = BW + 5;           // 20*B - offset
    localparam int unsigned CW   = X2W - 12;         // reciprocal of 7305, also C width
    localparam int unsigned DW   = CW + 11;          // 1461*C
    localparam int unsigned MW   = FRAC_BITS + 12;   // minute scaling product
    localparam int unsigned BDW  = jdc_pkg::BD_W;

    localparam logic [63:0] MA_FULL = (64'd1 << XAW) / 64'(jdc_pkg::ALPHA_DIV);
    localparam logic [63:0] MC_FULL = (64'd1 << X2W) / 64'(jdc_pkg::C_DIV);
    localparam logic [MAW-1:0] MA   = MA_FULL[MAW-1:0];
    localparam logic [CW-1:0]  MC   = MC_FULL[CW-1:0];

    // ------------------------------------------------------------------
    // Valid bits and per-stage ready chain
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;
    logic [NST-1:0] load;

    always_comb
    begin
        rdy[NST] = !cal_stall;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    // a stage loads new payload when it is free to move and its source is full
    always_comb
    begin
        load[0] = rdy[0] && date_valid;
        for (int k = 1; k < NST; k++)
        begin
            load[k] = rdy[k] && vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= date_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign date_stall = !rdy[0];
    assign cal_valid  = vld_reg[NST-1];

    // ------------------------------------------------------------------
    // Stage 1: add half a day, scale fraction to minutes
    // ------------------------------------------------------------------
    logic [FRAC_BITS:0]    s1_frac_half;
    logic [MW-1:0]         s1_prod;
    logic [DAY_BITS-1:0]   s1_whole_reg;
    logic [11:0]           s1_mins_reg;

    assign s1_frac_half = {1'b0, julian_date[FRAC_BITS-1:0]}
                        + ((FRAC_BITS + 1)'(1) << (FRAC_BITS - 1));
    assign s1_prod      = MW'(s1_frac_half) * MW'(jdc_pkg::MIN_PER_DAY);

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s1_whole_reg <= julian_date[DAY_BITS+FRAC_BITS-1:FRAC_BITS];
            s1_mins_reg  <= s1_prod[MW-1:FRAC_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: fold minute overflow into the day number
    // ------------------------------------------------------------------
    logic            s2_wrap;
    logic [ZW-1:0]   s2_z;
    logic [11:0]     s2_mins_adj;
    logic [ZW-1:0]   s2_z_reg;
    logic [10:0]     s2_mod_reg;
    logic            s2_greg_reg;
    logic [XAW-1:0]  s2_xa_reg;

    assign s2_wrap     = s1_mins_reg >= 12'(jdc_pkg::MIN_PER_DAY);
    assign s2_z        = ZW'(s1_whole_reg) + ZW'(s2_wrap);
    assign s2_mins_adj = s2_wrap ? s1_mins_reg - 12'(jdc_pkg::MIN_PER_DAY) : s1_mins_reg;

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s2_z_reg    <= s2_z;
            s2_mod_reg  <= s2_mins_adj[10:0];
            s2_greg_reg <= s2_z >= ZW'(jdc_pkg::GREG_START);
            s2_xa_reg   <= (XAW'(s2_z) << 2) - XAW'(jdc_pkg::ALPHA_OFS);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: alpha estimate by reciprocal, hour by reciprocal
    // ------------------------------------------------------------------
    logic [XAW+MAW-1:0] s3_pa;
    logic [25:0]        s3_ph;
    logic [ZW-1:0]      s3_z_reg;
    logic               s3_greg_reg;
    logic [XAW-1:0]     s3_xa_reg;
    logic [MAW-1:0]     s3_qa_reg;
    logic [10:0]        s3_mod_reg;
    logic [4:0]         s3_hour_reg;

    assign s3_pa = (XAW + MAW)'(s2_xa_reg) * (XAW + MAW)'(MA);
    assign s3_ph = 26'(s2_mod_reg) * 26'(jdc_pkg::HOUR_MUL);

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            s3_z_reg    <= s2_z_reg;
            s3_greg_reg <= s2_greg_reg;
            s3_xa_reg   <= s2_xa_reg;
            s3_qa_reg   <= s3_pa[XAW+MAW-1:XAW];
            s3_mod_reg  <= s2_mod_reg;
            s3_hour_reg <= s3_ph[jdc_pkg::HOUR_SHIFT+4:jdc_pkg::HOUR_SHIFT];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: correct alpha, split off minute
    // ------------------------------------------------------------------
    logic [XAW:0]   s4_rem;
    logic [10:0]    s4_min_full;
    logic [ZW-1:0]  s4_z_reg;
    logic           s4_greg_reg;
    logic [MAW-1:0] s4_alpha_reg;
    logic [4:0]     s4_hour_reg;
    logic [5:0]     s4_minute_reg;

    assign s4_rem      = (XAW + 1)'(s3_xa_reg)
                       - (XAW + 1)'(s3_qa_reg) * (XAW + 1)'(jdc_pkg::ALPHA_DIV);
    assign s4_min_full = s3_mod_reg - 11'(s3_hour_reg) * 11'(jdc_pkg::MIN_PER_HOUR);

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            s4_z_reg      <= s3_z_reg;
            s4_greg_reg   <= s3_greg_reg;
            s4_alpha_reg  <= s3_qa_reg + MAW'(s4_rem >= (XAW + 1)'(jdc_pkg::ALPHA_DIV));
            s4_hour_reg   <= s3_hour_reg;
            s4_minute_reg <= s4_min_full[5:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: Gregorian correction, B and 20*B - 2442
    // ------------------------------------------------------------------
    logic [BW-1:0]  s5_a;
    logic [BW-1:0]  s5_b;
    logic [BW-1:0]  s5_b_reg;
    logic [X2W-1:0] s5_x2_reg;
    logic [4:0]     s5_hour_reg;
    logic [5:0]     s5_minute_reg;

    assign s5_a = s4_greg_reg
                ? BW'(s4_z_reg) + BW'(1) + BW'(s4_alpha_reg) - BW'(s4_alpha_reg >> 2)
                : BW'(s4_z_reg);
    assign s5_b = s5_a + BW'(jdc_pkg::B_OFS);

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            s5_b_reg      <= s5_b;
            s5_x2_reg     <= (X2W'(s5_b) << 4) + (X2W'(s5_b) << 2) - X2W'(jdc_pkg::C_OFS);
            s5_hour_reg   <= s4_hour_reg;
            s5_minute_reg <= s4_minute_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: C estimate by reciprocal
    // ------------------------------------------------------------------
    logic [X2W+CW-1:0] s6_pc;
    logic [BW-1:0]     s6_b_reg;
    logic [X2W-1:0]    s6_x2_reg;
    logic [CW-1:0]     s6_qc_reg;
    logic [4:0]        s6_hour_reg;
    logic [5:0]        s6_minute_reg;

    assign s6_pc = (X2W + CW)'(s5_x2_reg) * (X2W + CW)'(MC);

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            s6_b_reg      <= s5_b_reg;
            s6_x2_reg     <= s5_x2_reg;
            s6_qc_reg     <= s6_pc[X2W+CW-1:X2W];
            s6_hour_reg   <= s5_hour_reg;
            s6_minute_reg <= s5_minute_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: correct C
    // ------------------------------------------------------------------
    logic [X2W:0]   s7_rem;
    logic [BW-1:0]  s7_b_reg;
    logic [CW-1:0]  s7_c_reg;
    logic [4:0]     s7_hour_reg;
    logic [5:0]     s7_minute_reg;

    assign s7_rem = (X2W + 1)'(s6_x2_reg)
                  - (X2W + 1)'(s6_qc_reg) * (X2W + 1)'(jdc_pkg::C_DIV);

    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            s7_b_reg      <= s6_b_reg;
            s7_c_reg      <= s6_qc_reg + CW'(s7_rem >= (X2W + 1)'(jdc_pkg::C_DIV));
            s7_hour_reg   <= s6_hour_reg;
            s7_minute_reg <= s6_minute_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: D = floor(1461*C/4), days into the shifted year
    // ------------------------------------------------------------------
    logic [DW-1:0]  s8_d4;
    logic [DW-3:0]  s8_bd_full;
    logic [CW-1:0]  s8_c_reg;
    logic [BDW-1:0] s8_bd_reg;
    logic [4:0]     s8_hour_reg;
    logic [5:0]     s8_minute_reg;

    assign s8_d4      = DW'(s7_c_reg) * DW'(jdc_pkg::D_MUL);
    assign s8_bd_full = (DW - 2)'(s7_b_reg) - s8_d4[DW-1:2];

    always_ff @(posedge clk)
    begin
        if (load[7])
        begin
            s8_c_reg      <= s7_c_reg;
            s8_bd_reg     <= s8_bd_full[BDW-1:0];
            s8_hour_reg   <= s7_hour_reg;
            s8_minute_reg <= s7_minute_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: month slot E by threshold compares
    // ------------------------------------------------------------------
    logic [3:0]     s9_e;
    logic [CW-1:0]  s9_c_reg;
    logic [BDW-1:0] s9_bd_reg;
    logic [3:0]     s9_e_reg;
    logic [4:0]     s9_hour_reg;
    logic [5:0]     s9_minute_reg;

    // thresholds are monotonic; the highest one passed gives E
    always_comb
    begin
        s9_e = 4'd0;
        for (int k = 1; k < 16; k++)
        begin
            if (s8_bd_reg > jdc_pkg::e_days(4'(k)))
            begin
                s9_e = 4'(k);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[8])
        begin
            s9_c_reg      <= s8_c_reg;
            s9_bd_reg     <= s8_bd_reg;
            s9_e_reg      <= s9_e;
            s9_hour_reg   <= s8_hour_reg;
            s9_minute_reg <= s8_minute_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: day, month, year; output register
    // ------------------------------------------------------------------
    logic [BDW-1:0] s10_day;
    logic [3:0]     s10_month;
    logic [CW:0]    s10_year;
    logic [15:0]    year_reg;
    logic [3:0]     month_reg;
    logic [4:0]     day_reg;
    logic [4:0]     hour_reg;
    logic [5:0]     minute_reg;

    assign s10_day   = s9_bd_reg - jdc_pkg::e_days(s9_e_reg);
    assign s10_month = (s9_e_reg < jdc_pkg::E_MONTH_WRAP) ? s9_e_reg - jdc_pkg::E_OFS_EARLY
                                                          : s9_e_reg - jdc_pkg::E_OFS_LATE;
    // March onward belongs to the year that begins in the shifted calendar
    assign s10_year  = (s10_month > jdc_pkg::MONTH_FEB)
                     ? (CW + 1)'(s9_c_reg) - (CW + 1)'(jdc_pkg::YEAR_OFS_LATE)
                     : (CW + 1)'(s9_c_reg) - (CW + 1)'(jdc_pkg::YEAR_OFS_EARLY);

    always_ff @(posedge clk)
    begin
        if (load[9])
        begin
            year_reg   <= s10_year[15:0];
            month_reg  <= s10_month;
            day_reg    <= s10_day[4:0];
            hour_reg   <= s9_hour_reg;
            minute_reg <= s9_minute_reg;
        end
    end

    assign year         = $signed(year_reg);
    assign month        = month_reg;
    assign day_of_month = day_reg;
    assign hour         = hour_reg;
    assign minute       = minute_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && !rdy[0] |=> vld_reg[0])
        else $error("stage 1 dropped an item while held");

    a_minute_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> s4_minute_reg < 6'(jdc_pkg::MIN_PER_HOUR) && s4_hour_reg <= 5'd23)
        else $error("time of day split out of range");

    a_bd_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[7] |-> s8_bd_reg >= BDW'(jdc_pkg::BD_MIN) && s8_bd_reg <= BDW'(jdc_pkg::BD_MAX))
        else $error("day count within shifted year out of range");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_valid |-> month >= 4'd1 && month <= 4'd12
                   && day_of_month >= 5'd1 && day_of_month <= 5'd31)
        else $error("calendar result out of range");

endmodule

FILE: test/tb_julian_date_to_calendar.sv
// Self-checking testbench for the Julian date to calendar date converter.
module tb_julian_date_to_calendar;

    localparam int unsigned DATE_W      = jdc_pkg::DAY_BITS_DEF + jdc_pkg::FRAC_BITS_DEF;
    localparam int unsigned DAY_W       = jdc_pkg::DAY_BITS_DEF;
    localparam int unsigned FRAC_W      = jdc_pkg::FRAC_BITS_DEF;
    localparam int unsigned IDLE_LIMIT  = 4000;
    localparam int unsigned SETTLE_CYC  = 30;
    localparam int unsigned PHASE_ITEMS = 540;

    // One calendar result as the block presents it.
    typedef struct packed {
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day_of_month;
        logic [4:0]         hour;
        logic [5:0]         minute;
    } cal_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              date_valid   = 1'b0;
    logic              date_stall;
    logic [DATE_W-1:0] julian_date  = '0;
    logic              cal_valid;
    logic              cal_stall    = 1'b0;
    logic signed [15:0] year;
    logic [3:0]        month;
    logic [4:0]        day_of_month;
    logic [4:0]        hour;
    logic [5:0]        minute;

    logic [DATE_W-1:0] pending_dates[$];
    cal_t              expected_cal[$];
    int unsigned       sender_idle_pct   = 0;
    int unsigned       receiver_idle_pct = 0;
    int unsigned       mismatch_count    = 0;
    int unsigned       quiet_cycles      = 0;

    julian_date_to_calendar uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .date_valid   (date_valid),
        .date_stall   (date_stall),
        .julian_date  (julian_date),
        .cal_valid    (cal_valid),
        .cal_stall    (cal_stall),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .hour         (hour),
        .minute       (minute)
    );

    always #5 clk = ~clk;

    // Calendar date and time of day for one fixed-point Julian date.
    // Add half a day, floor to whole minutes, then run the Meeus split with
    // every fractional constant kept as an exact integer ratio.
    function automatic cal_t calendar_of(input logic [DATE_W-1:0] jd);
        longint unsigned whole;
        longint unsigned frac;
        longint unsigned mins;
        longint unsigned z;
        longint unsigned a;
        longint unsigned b;
        longint unsigned c;
        longint unsigned d;
        longint unsigned e;
        longint unsigned alpha;
        longint unsigned dom;
        longint unsigned mon;
        longint          yr;
        cal_t            r;
        whole = longint'(jd >> FRAC_W);
        frac  = longint'(jd[FRAC_W-1:0]);
        mins  = ((frac + (64'd1 << (FRAC_W - 1))) * jdc_pkg::MIN_PER_DAY) >> FRAC_W;
        z     = whole;
        // The half-day offset may push the minute count into the next day.
        if (mins >= jdc_pkg::MIN_PER_DAY)
        begin
            z    = z + 1;
            mins = mins - jdc_pkg::MIN_PER_DAY;
        end
        a = z;
        if (z >= jdc_pkg::GREG_START)
        begin
            alpha = (4 * z - jdc_pkg::ALPHA_OFS) / jdc_pkg::ALPHA_DIV;
            a     = z + 1 + alpha - alpha / 4;
        end
        b   = a + jdc_pkg::B_OFS;
        c   = (20 * b - jdc_pkg::C_OFS) / jdc_pkg::C_DIV;
        d   = (jdc_pkg::D_MUL * c) / 4;
        e   = (10000 * (b - d)) / 306001;
        dom = b - d - (306001 * e) / 10000;
        mon = (e < jdc_pkg::E_MONTH_WRAP) ? e - jdc_pkg::E_OFS_EARLY : e - jdc_pkg::E_OFS_LATE;
        yr  = (mon > jdc_pkg::MONTH_FEB) ? longint'(c) - jdc_pkg::YEAR_OFS_LATE
                                         : longint'(c) - jdc_pkg::YEAR_OFS_EARLY;
        r.year         = yr[15:0];
        r.month        = mon[3:0];
        r.day_of_month = dom[4:0];
        r.hour         = 5'((mins / jdc_pkg::MIN_PER_HOUR) & 64'h1F);
        r.minute       = 6'((mins % jdc_pkg::MIN_PER_HOUR) & 64'h3F);
        return r;
    endfunction

    // Build a date from a day number and a raw fraction.
    function automatic logic [DATE_W-1:0] date_of(input int unsigned day,
                                                   input int unsigned frac);
        return {day[DAY_W-1:0], frac[FRAC_W-1:0]};
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] %s", $realtime, msg);
    endtask

    // Random date with weight on the spots that matter: the calendar switch,
    // the modern era, the earliest days, and fractions near the midnight carry.
    function automatic logic [DATE_W-1:0] random_date();
        int unsigned day;
        int unsigned frac;
        case ($urandom_range(0, 3))
            0:       day = $urandom_range(0, (1 << DAY_W) - 1);
            1:       day = $urandom_range(jdc_pkg::GREG_START - 60000,
                                          jdc_pkg::GREG_START + 60000);
            2:       day = $urandom_range(2400000, 2500000);
            default: day = $urandom_range(0, 4000);
        endcase
        case ($urandom_range(0, 3))
            0:       frac = $urandom_range(0, (1 << FRAC_W) - 1);
            1:       frac = $urandom_range(16'h7F00, 16'h80FF);
            2:       frac = $urandom_range(0, 1) ? $urandom_range(0, 63)
                                                 : $urandom_range(16'hFFC0, 16'hFFFF);
            default: frac = ($urandom_range(0, 1439) * 65536 + 1439) / 1440;
        endcase
        return date_of(day, frac);
    endfunction

    // Driver: present the next pending date, hold it while stalled, and
    // record the expected calendar result on every transfer.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            date_valid <= 1'b0;
        end
        else
        begin
            if (date_valid && !date_stall)
                expected_cal.push_back(calendar_of(julian_date));
            if (date_valid && date_stall)
            begin
                // hold: payload and valid stay put until the transfer happens
            end
            else if (pending_dates.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                date_valid  <= 1'b1;
                julian_date <= pending_dates.pop_front();
            end
            else
            begin
                date_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall the result channel at random and check every transfer
    // against the oldest expectation, field by field.
    always @(posedge clk)
    begin
        cal_t want;
        if (rst_n)
        begin
            if (cal_valid && !cal_stall)
            begin
                if (expected_cal.size() == 0)
                begin
                    report_mismatch("result with no date pending");
                end
                else
                begin
                    want = expected_cal.pop_front();
                    if (year !== want.year)
                        report_mismatch($sformatf("year mismatch: got %0d, want %0d",
                                                  year, want.year));
                    if (month !== want.month)
                        report_mismatch($sformatf("month mismatch: got %0d, want %0d",
                                                  month, want.month));
                    if (day_of_month !== want.day_of_month)
                        report_mismatch($sformatf("day_of_month mismatch: got %0d, want %0d",
                                                  day_of_month, want.day_of_month));
                    if (hour !== want.hour)
                        report_mismatch($sformatf("hour mismatch: got %0d, want %0d",
                                                  hour, want.hour));
                    if (minute !== want.minute)
                        report_mismatch($sformatf("minute mismatch: got %0d, want %0d",
                                                  minute, want.minute));
                end
            end
            cal_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    // Watchdog: end the run if no transfer happens on either channel for
    // too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((date_valid && !date_stall) || (cal_valid && !cal_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer in %0d cycles", IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        // Directed dates: field extremes, midnight carry, calendar switch,
        // leap days and the last minute of a day.
        pending_dates.push_back('0);                                  // day zero, noon
        pending_dates.push_back({DATE_W{1'b1}});                      // largest date
        pending_dates.push_back(date_of(0, 16'h8000));                // day zero carries to day one
        pending_dates.push_back(date_of(0, 16'hFFFF));
        pending_dates.push_back(date_of(2451545, 16'h0000));          // noon, start of 2000
        pending_dates.push_back(date_of(2451544, 16'h7FFF));          // just before midnight
        pending_dates.push_back(date_of(2451544, 16'h8000));          // exact midnight carry
        pending_dates.push_back(date_of(2451544, 16'h7FD3));          // 23:59
        pending_dates.push_back(date_of(2451544, 16'h7FD2));          // 23:58
        pending_dates.push_back(date_of(2299160, 16'h0000));          // last Julian day
        pending_dates.push_back(date_of(2299160, 16'h7FFF));
        pending_dates.push_back(date_of(2299160, 16'h8000));          // carry into Gregorian
        pending_dates.push_back(date_of(2299161, 16'h0000));          // first Gregorian day
        pending_dates.push_back(date_of(2451603, 16'h8000));          // leap day 2000
        pending_dates.push_back(date_of(2415078, 16'h8000));          // 1900, no leap day
        pending_dates.push_back(date_of(2415079, 16'h8000));
        pending_dates.push_back(date_of(2459580, 16'h8000));          // new year boundary
        pending_dates.push_back(date_of(2459579, 16'hFFFF));
        pending_dates.push_back(date_of(1721423, 16'h8000));          // around year zero
        pending_dates.push_back(date_of((1 << DAY_W) - 1, 16'h0000));
        pending_dates.push_back(date_of(12345, 16'h5555));            // alternating bits
        pending_dates.push_back(date_of(5592405, 16'hAAAA));

        // Phase one: sender idles often, receiver stalls heavily.
        sender_idle_pct   = 36;
        receiver_idle_pct = 71;
        repeat (PHASE_ITEMS) pending_dates.push_back(random_date());
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 1; phase <= 3; phase++)
        begin
            // Drain before moving on: the sender waits for every result.
            while (pending_dates.size() > 0 || date_valid || expected_cal.size() > 0)
                @(posedge clk);
            if (phase == 1)
            begin
                sender_idle_pct   = 71;
                receiver_idle_pct = 36;
                repeat (PHASE_ITEMS) pending_dates.push_back(random_date());
            end
            else if (phase == 2)
            begin
                // Full rate on both sides.
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
                repeat (PHASE_ITEMS) pending_dates.push_back(random_date());
            end
        end

        // Let any stray output surface before the verdict.
        repeat (SETTLE_CYC) @(posedge clk);
        if (mismatch_count == 0 && expected_cal.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
